[rtl/core/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the two-table cuckoo hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int MOD_W       = 15;
    localparam int KICK_W      = 10;
    localparam int CNT_W       = 16;
    localparam int MUL_W       = 6;
    localparam int ACC_W       = 20;
    localparam int STEP_N      = 8;
    localparam int STEP_W      = $clog2(STEP_N);

    localparam logic [MUL_W-1:0]  MUL_ONE    = 6'd37;
    localparam logic [MUL_W-1:0]  MUL_TWO    = 6'd41;
    localparam logic [MOD_W-1:0]  MOD_RESET  = 15'd10007;
    localparam logic [KICK_W-1:0] KICK_RESET = 10'd500;
    localparam logic [MOD_W-1:0]  MOD_MIN    = 15'd2;
    localparam logic [MOD_W-1:0]  MOD_MAX    = MOD_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(KEY_CHARS);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_KICK    = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } tbl_req_t;

    typedef struct packed {
        logic             start;
        logic             second;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } hash_req_t;

    typedef struct packed {
        logic [MOD_W-1:0]  modulus;
        logic [KICK_W-1:0] kick_limit;
    } cfg_t;

endpackage

[rtl/core/chs_hash.sv]
// ----------------------------------------------------------------------------
// chs_hash
// Shared polynomial hash unit: one multiply-add per byte, then eight
// compare-and-subtract steps reduce the sum modulo the configured modulus.
// ----------------------------------------------------------------------------
module chs_hash
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  chs_pkg::hash_req_t          req,
    input  logic [chs_pkg::MOD_W-1:0]   modulus,
    output logic                        done,
    output logic [chs_pkg::IDX_W-1:0]   hash
);

    logic                              busy_reg;
    logic                              reduce_reg;
    logic                              done_reg;
    logic [chs_pkg::STEP_W-1:0]        step_reg;
    logic [2:0]                        byte_reg;
    logic [chs_pkg::ACC_W-1:0]         acc_reg;
    logic [chs_pkg::IDX_W-1:0]         hash_reg;
    logic [chs_pkg::KEY_W-1:0]         key_reg;
    logic [chs_pkg::LEN_W-1:0]         len_reg;
    logic [chs_pkg::MUL_W-1:0]         mul_reg;

    logic [7:0]                        byte_val;
    logic [chs_pkg::ACC_W-1:0]         mac;
    logic [chs_pkg::ACC_W+1:0]         div_val;
    logic                              acc_ge;
    logic [chs_pkg::ACC_W-1:0]         acc_red;
    logic                              last_byte;

    assign byte_val  = key_reg[{byte_reg, 3'b000} +: 8];
    assign mac       = chs_pkg::ACC_W'(hash_reg) * chs_pkg::ACC_W'(mul_reg)
                       + chs_pkg::ACC_W'(byte_val);
    assign div_val   = (chs_pkg::ACC_W+2)'(modulus) << step_reg;
    assign acc_ge    = {2'b00, acc_reg} >= div_val;
    assign acc_red   = acc_ge ? acc_reg - div_val[chs_pkg::ACC_W-1:0] : acc_reg;
    assign last_byte = ({1'b0, byte_reg} + 4'd1) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            reduce_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    reduce_reg <= 1'b0;
                    if (req.len == '0)
                        done_reg <= 1'b1;
                    else
                        busy_reg <= 1'b1;
                end
            end
            else if (!reduce_reg)
            begin
                reduce_reg <= 1'b1;
            end
            else if (step_reg == '0)
            begin
                reduce_reg <= 1'b0;
                if (last_byte)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (req.start)
            begin
                key_reg  <= req.key;
                len_reg  <= req.len;
                mul_reg  <= req.second ? chs_pkg::MUL_TWO : chs_pkg::MUL_ONE;
                hash_reg <= '0;
                byte_reg <= '0;
            end
        end
        else if (!reduce_reg)
        begin
            acc_reg  <= mac;
            step_reg <= chs_pkg::STEP_W'(chs_pkg::STEP_N - 1);
        end
        else
        begin
            acc_reg  <= acc_red;
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                hash_reg <= acc_red[chs_pkg::IDX_W-1:0];
                byte_reg <= byte_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

[rtl/core/chs_table.sv]
// ----------------------------------------------------------------------------
// chs_table
// One cuckoo table: single-port memory of entries, registered read.
// ----------------------------------------------------------------------------
module chs_table
(
    input  logic                clk,
    input  chs_pkg::tbl_req_t   req,
    output chs_pkg::entry_t     rdata
);

    chs_pkg::entry_t mem [chs_pkg::TABLE_DEPTH];
    chs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.addr] <= req.wdata;
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/chs_regs.sv]
// ----------------------------------------------------------------------------
// chs_regs
// APB configuration registers: table modulus and kick limit.
// ----------------------------------------------------------------------------
module chs_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output chs_pkg::cfg_t cfg
);

    logic [chs_pkg::MOD_W-1:0]  modulus_reg;
    logic [chs_pkg::KICK_W-1:0] kick_reg;
    logic                       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= chs_pkg::MOD_RESET;
            kick_reg    <= chs_pkg::KICK_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == chs_pkg::REG_MODULUS)
                modulus_reg <= pwdata[chs_pkg::MOD_W-1:0];
            else
                kick_reg <= pwdata[chs_pkg::KICK_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == chs_pkg::REG_MODULUS)
            prdata = 32'(modulus_reg);
        else
            prdata = 32'(kick_reg);
    end

    assign cfg.modulus    = modulus_reg;
    assign cfg.kick_limit = kick_reg;

endmodule

[rtl/core/cuckoo_hash_set_core.sv]
// ----------------------------------------------------------------------------
// cuckoo_hash_set_core
// Two-table cuckoo hash set with insert, lookup and remove on short keys.
//
//   channel   signals                                           handshake
//   command   func, key_bytes, key_length                       start / busy
//   result    status, entry_count, homeless_key, homeless_length done strobe
//   config    psel, penable, pwrite, paddr, pwdata, prdata      APB, pready=1
//
// Each hash runs byte by byte in the shared modulo unit; an item needs two
// hashes plus a table read, and each kick round adds two hashes and two
// table accesses. A lookup or remove strobes its result once both hashes
// and the read are done; busy falls with the strobe, so the next item may
// start while it shows. After reset a clearing pass empties both tables
// while busy stays high. The result strobe lasts one cycle and cannot stall.
// ----------------------------------------------------------------------------
module cuckoo_hash_set_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic [chs_pkg::KEY_W-1:0]     key_bytes,
    input  logic [chs_pkg::LEN_W-1:0]     key_length,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [chs_pkg::CNT_W-1:0]     entry_count,
    output logic [chs_pkg::KEY_W-1:0]     homeless_key,
    output logic [chs_pkg::LEN_W-1:0]     homeless_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_H1    = 4'd2;
    localparam logic [3:0] S_H2    = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_KH1   = 4'd5;
    localparam logic [3:0] S_KC1   = 4'd6;
    localparam logic [3:0] S_KH2   = 4'd7;
    localparam logic [3:0] S_KC2   = 4'd8;

    chs_pkg::cfg_t      cfg;
    chs_pkg::hash_req_t hreq;
    chs_pkg::tbl_req_t  t1_req;
    chs_pkg::tbl_req_t  t2_req;
    chs_pkg::entry_t    t1_rd;
    chs_pkg::entry_t    t2_rd;
    logic                          hdone;
    logic [chs_pkg::IDX_W-1:0]     hval;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic [chs_pkg::IDX_W-1:0]     clr_reg;
    logic [1:0]                    func_reg;
    logic [chs_pkg::KEY_W-1:0]     key_reg;
    logic [chs_pkg::LEN_W-1:0]     len_reg;
    logic [chs_pkg::KEY_W-1:0]     ck_reg;
    logic [chs_pkg::KEY_W-1:0]     ck_next;
    logic [chs_pkg::LEN_W-1:0]     cl_reg;
    logic [chs_pkg::LEN_W-1:0]     cl_next;
    logic [chs_pkg::IDX_W-1:0]     p1_reg;
    logic [chs_pkg::IDX_W-1:0]     p2_reg;
    logic [chs_pkg::IDX_W-1:0]     s_reg;
    logic [chs_pkg::KICK_W-1:0]    rounds_reg;
    logic [chs_pkg::KICK_W-1:0]    rounds_next;
    logic [chs_pkg::CNT_W-1:0]     count_reg;
    logic [chs_pkg::CNT_W-1:0]     count_next;
    logic                          done_reg;
    logic [1:0]                    status_reg;
    logic [chs_pkg::KEY_W-1:0]     hkey_reg;
    logic [chs_pkg::LEN_W-1:0]     hlen_reg;

    logic                          accept;
    logic                          fin;
    logic [1:0]                    fin_status;
    logic [chs_pkg::KEY_W-1:0]     fin_hkey;
    logic [chs_pkg::LEN_W-1:0]     fin_hlen;
    logic [chs_pkg::MOD_W-1:0]     m_eff;
    logic [chs_pkg::LEN_W-1:0]     norm_len;
    logic [chs_pkg::KEY_W-1:0]     norm_key;
    logic                          hit1;
    logic                          hit2;
    logic                          over_half;

    chs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    chs_hash u_hash
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hreq),
        .modulus (m_eff),
        .done    (hdone),
        .hash    (hval)
    );

    chs_table u_tbl1
    (
        .clk   (clk),
        .req   (t1_req),
        .rdata (t1_rd)
    );

    chs_table u_tbl2
    (
        .clk   (clk),
        .req   (t2_req),
        .rdata (t2_rd)
    );

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;

    always_comb
    begin
        if (cfg.modulus < chs_pkg::MOD_MIN)
            m_eff = chs_pkg::MOD_MIN;
        else if (cfg.modulus > chs_pkg::MOD_MAX)
            m_eff = chs_pkg::MOD_MAX;
        else
            m_eff = cfg.modulus;
    end

    always_comb
    begin
        norm_len = (key_length > chs_pkg::LEN_MAX) ? chs_pkg::LEN_MAX : key_length;
        for (int i = 0; i < chs_pkg::KEY_CHARS; i++)
        begin
            norm_key[8*i +: 8] = (chs_pkg::LEN_W'(i) < norm_len) ? key_bytes[8*i +: 8]
                                                                 : 8'h00;
        end
    end

    assign hit1 = t1_rd.valid && t1_rd.len == len_reg && t1_rd.key == key_reg;
    assign hit2 = t2_rd.valid && t2_rd.len == len_reg && t2_rd.key == key_reg;
    assign over_half = {count_reg, 1'b0} > (chs_pkg::CNT_W+1)'(m_eff);

    always_comb
    begin
        state_next   = state_reg;
        ck_next      = ck_reg;
        cl_next      = cl_reg;
        rounds_next  = rounds_reg;
        count_next   = count_reg;
        fin          = 1'b0;
        fin_status   = chs_pkg::ST_ABSENT;
        fin_hkey     = '0;
        fin_hlen     = '0;
        hreq         = '0;
        t1_req       = '0;
        t2_req       = '0;
        t1_req.addr  = p1_reg;
        t2_req.addr  = p2_reg;

        case (state_reg)
            S_CLEAR:
            begin
                t1_req.we   = 1'b1;
                t1_req.addr = clr_reg;
                t2_req.we   = 1'b1;
                t2_req.addr = clr_reg;
                if (clr_reg == chs_pkg::IDX_W'(chs_pkg::TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == chs_pkg::FUNC_INSERT || func == chs_pkg::FUNC_LOOKUP
                        || func == chs_pkg::FUNC_REMOVE)
                    begin
                        hreq.start = 1'b1;
                        hreq.key   = norm_key;
                        hreq.len   = norm_len;
                        state_next = S_H1;
                    end
                    else
                    begin
                        state_next = S_DEC;
                    end
                end
            end
            S_H1:
            begin
                if (hdone)
                begin
                    hreq.start  = 1'b1;
                    hreq.second = 1'b1;
                    hreq.key    = key_reg;
                    hreq.len    = len_reg;
                    state_next  = S_H2;
                end
            end
            S_H2:
            begin
                t2_req.addr = hval;
                if (hdone)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                fin        = 1'b1;
                case (func_reg)
                    chs_pkg::FUNC_LOOKUP:
                    begin
                        fin_status = (hit1 || hit2) ? chs_pkg::ST_PRESENT
                                                    : chs_pkg::ST_ABSENT;
                    end
                    chs_pkg::FUNC_REMOVE:
                    begin
                        if (hit1)
                        begin
                            t1_req.we          = 1'b1;
                            t1_req.wdata       = t1_rd;
                            t1_req.wdata.valid = 1'b0;
                            count_next         = count_reg - 1'b1;
                            fin_status         = chs_pkg::ST_PRESENT;
                        end
                        else if (hit2)
                        begin
                            t2_req.we          = 1'b1;
                            t2_req.wdata       = t2_rd;
                            t2_req.wdata.valid = 1'b0;
                            count_next         = count_reg - 1'b1;
                            fin_status         = chs_pkg::ST_PRESENT;
                        end
                    end
                    chs_pkg::FUNC_INSERT:
                    begin
                        if (hit1 || hit2)
                        begin
                            fin_status = chs_pkg::ST_PRESENT;
                        end
                        else if (over_half)
                        begin
                            fin_status = chs_pkg::ST_FULL;
                        end
                        else if (cfg.kick_limit == '0)
                        begin
                            fin_status = chs_pkg::ST_FULL;
                            fin_hkey   = key_reg;
                            fin_hlen   = len_reg;
                        end
                        else
                        begin
                            fin         = 1'b0;
                            ck_next     = key_reg;
                            cl_next     = len_reg;
                            rounds_next = '0;
                            hreq.start  = 1'b1;
                            hreq.key    = key_reg;
                            hreq.len    = len_reg;
                            state_next  = S_KH1;
                        end
                    end
                    default:
                    begin
                        fin_status = chs_pkg::ST_ABSENT;
                    end
                endcase
            end
            S_KH1:
            begin
                t1_req.addr = hval;
                if (hdone)
                    state_next = S_KC1;
            end
            S_KC1:
            begin
                t1_req.we          = 1'b1;
                t1_req.addr        = s_reg;
                t1_req.wdata.valid = 1'b1;
                t1_req.wdata.len   = cl_reg;
                t1_req.wdata.key   = ck_reg;
                if (!t1_rd.valid)
                begin
                    fin        = 1'b1;
                    fin_status = chs_pkg::ST_INSERTED;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ck_next     = t1_rd.key;
                    cl_next     = t1_rd.len;
                    hreq.start  = 1'b1;
                    hreq.second = 1'b1;
                    hreq.key    = t1_rd.key;
                    hreq.len    = t1_rd.len;
                    state_next  = S_KH2;
                end
            end
            S_KH2:
            begin
                t2_req.addr = hval;
                if (hdone)
                    state_next = S_KC2;
            end
            S_KC2:
            begin
                t2_req.we          = 1'b1;
                t2_req.addr        = s_reg;
                t2_req.wdata.valid = 1'b1;
                t2_req.wdata.len   = cl_reg;
                t2_req.wdata.key   = ck_reg;
                if (!t2_rd.valid)
                begin
                    fin        = 1'b1;
                    fin_status = chs_pkg::ST_INSERTED;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else if (rounds_reg + 1'b1 == cfg.kick_limit)
                begin
                    fin        = 1'b1;
                    fin_status = chs_pkg::ST_FULL;
                    fin_hkey   = t2_rd.key;
                    fin_hlen   = t2_rd.len;
                    state_next = S_IDLE;
                end
                else
                begin
                    ck_next     = t2_rd.key;
                    cl_next     = t2_rd.len;
                    rounds_next = rounds_reg + 1'b1;
                    hreq.start  = 1'b1;
                    hreq.key    = t2_rd.key;
                    hreq.len    = t2_rd.len;
                    state_next  = S_KH1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= fin;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ck_reg     <= ck_next;
        cl_reg     <= cl_next;
        rounds_reg <= rounds_next;
        if (accept)
        begin
            func_reg <= func;
            key_reg  <= norm_key;
            len_reg  <= norm_len;
        end
        if (state_reg == S_H1 && hdone)
            p1_reg <= hval;
        if (state_reg == S_H2 && hdone)
            p2_reg <= hval;
        if (hdone)
            s_reg <= hval;
        if (fin)
        begin
            status_reg <= fin_status;
            hkey_reg   <= fin_hkey;
            hlen_reg   <= fin_hlen;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign entry_count     = count_reg;
    assign homeless_key    = hkey_reg;
    assign homeless_length = hlen_reg;

endmodule

[rtl/core/chs_checker.sv]
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the cuckoo hash set, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [1:0]                    status,
    input logic [chs_pkg::KEY_W-1:0]     homeless_key,
    input logic [chs_pkg::LEN_W-1:0]     homeless_length
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_homeless_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != chs_pkg::ST_FULL |-> homeless_key == '0 && homeless_length == '0)
        else $error("homeless key reported without full status");

    a_homeless_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> homeless_length <= chs_pkg::LEN_MAX)
        else $error("homeless length out of range");

endmodule

bind cuckoo_hash_set_core chs_checker u_chs_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .homeless_key    (homeless_key),
    .homeless_length (homeless_length)
);
